// ----- hw/rtl/amcc_pkg.sv -----
`timescale 1ns / 1ps

package amcc_pkg;

	localparam int MAX_CLASSES = 16;
	localparam int CLASS_BITS  = 4;
	localparam int SCORE_BITS  = 16;
	localparam int CNT_BITS    = 32;
	localparam int NCLS_BITS   = 5;
	localparam int ADDR_BITS   = 2 * CLASS_BITS;
	localparam int CELLS       = MAX_CLASSES * MAX_CLASSES;

	localparam logic [1:0] REQ_PUSH  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic KIND_ROW  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic                  hit;
		logic                  is_push;
		logic [ADDR_BITS-1:0]  addr;
		logic [CLASS_BITS-1:0] obs_class;
		logic [CLASS_BITS-1:0] pred_class;
		logic                  class_match;
		logic [CNT_BITS-1:0]   rows_seen;
		logic [CNT_BITS-1:0]   correct_rows;
	} cell_req_t;

	typedef struct packed {
		logic                  result_kind;
		logic [CLASS_BITS-1:0] obs_class;
		logic [CLASS_BITS-1:0] pred_class;
		logic                  class_match;
		logic [CNT_BITS-1:0]   cell_count;
		logic [CNT_BITS-1:0]   rows_seen;
		logic [CNT_BITS-1:0]   correct_rows;
	} result_t;

	function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] x);
		logic [CNT_BITS-1:0] r;
		r = (x == {CNT_BITS{1'b1}}) ? x : x + {{(CNT_BITS-1){1'b0}}, 1'b1};
		return r;
	endfunction

endpackage

// ----- hw/rtl/amcc_row_track.sv -----
`timescale 1ns / 1ps

module amcc_row_track (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	input  logic [amcc_pkg::NCLS_BITS-1:0]        cfg_data,
	input  logic                                  accept,
	input  logic [1:0]                            req_type,
	input  logic signed [amcc_pkg::SCORE_BITS-1:0] pred_score,
	input  logic signed [amcc_pkg::SCORE_BITS-1:0] obs_score,
	input  logic [amcc_pkg::CLASS_BITS-1:0]       read_row,
	input  logic [amcc_pkg::CLASS_BITS-1:0]       read_col,
	output amcc_pkg::cell_req_t                   req,
	output logic                                  clear
);

	logic [amcc_pkg::NCLS_BITS-1:0]         num_classes_q;
	logic [amcc_pkg::CLASS_BITS-1:0]        col_q;
	logic signed [amcc_pkg::SCORE_BITS-1:0] best_pred_q;
	logic signed [amcc_pkg::SCORE_BITS-1:0] best_obs_q;
	logic [amcc_pkg::CLASS_BITS-1:0]        best_pred_idx_q;
	logic [amcc_pkg::CLASS_BITS-1:0]        best_obs_idx_q;
	logic [amcc_pkg::CNT_BITS-1:0]          row_total_q;
	logic [amcc_pkg::CNT_BITS-1:0]          match_total_q;

	logic [amcc_pkg::NCLS_BITS-1:0]         n_act;
	logic                                   first_col;
	logic                                   pred_take;
	logic                                   obs_take;
	logic signed [amcc_pkg::SCORE_BITS-1:0] nxt_pred;
	logic signed [amcc_pkg::SCORE_BITS-1:0] nxt_obs;
	logic [amcc_pkg::CLASS_BITS-1:0]        nxt_pred_idx;
	logic [amcc_pkg::CLASS_BITS-1:0]        nxt_obs_idx;
	logic                                   row_done;
	logic                                   match;
	logic                                   is_push;
	logic                                   is_read;
	logic                                   is_clear;
	logic [amcc_pkg::CNT_BITS-1:0]          rows_inc;
	logic [amcc_pkg::CNT_BITS-1:0]          match_inc;

	always_comb begin
		is_push  = 1'b0;
		is_read  = 1'b0;
		is_clear = 1'b0;
		case (req_type)
			amcc_pkg::REQ_PUSH:  is_push = 1'b1;
			amcc_pkg::REQ_READ:  is_read = 1'b1;
			amcc_pkg::REQ_CLEAR: is_clear = 1'b1;
			default: begin
				is_push = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (num_classes_q == '0) begin
			n_act = amcc_pkg::NCLS_BITS'(1);
		end else if (num_classes_q > amcc_pkg::NCLS_BITS'(amcc_pkg::MAX_CLASSES)) begin
			n_act = amcc_pkg::NCLS_BITS'(amcc_pkg::MAX_CLASSES);
		end else begin
			n_act = num_classes_q;
		end
	end

	assign first_col    = (col_q == '0);
	assign pred_take    = first_col || (pred_score > best_pred_q);
	assign obs_take     = first_col || (obs_score > best_obs_q);
	assign nxt_pred     = pred_take ? pred_score : best_pred_q;
	assign nxt_obs      = obs_take ? obs_score : best_obs_q;
	assign nxt_pred_idx = pred_take ? col_q : best_pred_idx_q;
	assign nxt_obs_idx  = obs_take ? col_q : best_obs_idx_q;
	assign row_done     = ({1'b0, col_q} + amcc_pkg::NCLS_BITS'(1)) >= n_act;
	assign match        = (nxt_pred_idx == nxt_obs_idx);
	assign rows_inc     = amcc_pkg::sat_inc(row_total_q);
	assign match_inc    = amcc_pkg::sat_inc(match_total_q);

	always_comb begin
		req.hit          = accept && ((is_push && row_done) || is_read);
		req.is_push      = is_push;
		req.addr         = is_push ? {nxt_obs_idx, nxt_pred_idx} : {read_row, read_col};
		req.obs_class    = is_push ? nxt_obs_idx : read_row;
		req.pred_class   = is_push ? nxt_pred_idx : read_col;
		req.class_match  = is_push && match;
		req.rows_seen    = is_push ? rows_inc : row_total_q;
		req.correct_rows = (is_push && match) ? match_inc : match_total_q;
	end

	assign clear = accept && is_clear;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_classes_q   <= amcc_pkg::NCLS_BITS'(amcc_pkg::MAX_CLASSES);
			col_q           <= '0;
			best_pred_q     <= '0;
			best_obs_q      <= '0;
			best_pred_idx_q <= '0;
			best_obs_idx_q  <= '0;
			row_total_q     <= '0;
			match_total_q   <= '0;
		end else begin
			if (cfg_valid) begin
				num_classes_q <= cfg_data;
			end
			if (accept && is_push) begin
				best_pred_q     <= nxt_pred;
				best_obs_q      <= nxt_obs;
				best_pred_idx_q <= nxt_pred_idx;
				best_obs_idx_q  <= nxt_obs_idx;
				if (row_done) begin
					col_q       <= '0;
					row_total_q <= rows_inc;
					if (match) begin
						match_total_q <= match_inc;
					end
				end else begin
					col_q <= col_q + amcc_pkg::CLASS_BITS'(1);
				end
			end else if (accept && is_clear) begin
				col_q           <= '0;
				best_pred_q     <= '0;
				best_obs_q      <= '0;
				best_pred_idx_q <= '0;
				best_obs_idx_q  <= '0;
				row_total_q     <= '0;
				match_total_q   <= '0;
			end
		end
	end

endmodule

// ----- hw/rtl/amcc_cell_store.sv -----
`timescale 1ns / 1ps

module amcc_cell_store (
	input  logic                clk,
	input  logic                arst_n,
	input  amcc_pkg::cell_req_t req,
	input  logic                clear,
	input  logic                adv,
	output logic                res_valid,
	output amcc_pkg::result_t   res
);

	logic [amcc_pkg::CNT_BITS-1:0] mem [amcc_pkg::CELLS];
	logic [amcc_pkg::CELLS-1:0]    cell_valid_q;

	logic                          valid_s1;
	amcc_pkg::cell_req_t           req_s1;
	logic [amcc_pkg::CNT_BITS-1:0] rd_s1;
	logic                          vld_s1;
	logic                          fwd_s1;
	logic [amcc_pkg::CNT_BITS-1:0] fwd_data_s1;

	logic [amcc_pkg::CNT_BITS-1:0] base;
	logic [amcc_pkg::CNT_BITS-1:0] cnt;
	logic                          write;

	assign base  = fwd_s1 ? fwd_data_s1 : (vld_s1 ? rd_s1 : '0);
	assign cnt   = req_s1.is_push ? amcc_pkg::sat_inc(base) : base;
	assign write = valid_s1 && adv && req_s1.is_push;

	always_ff @(posedge clk) begin
		if (write) begin
			mem[req_s1.addr] <= cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (req.hit) begin
			rd_s1       <= mem[req.addr];
			vld_s1      <= cell_valid_q[req.addr];
			fwd_s1      <= write && (req_s1.addr == req.addr);
			fwd_data_s1 <= cnt;
			req_s1      <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_valid_q <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (clear) begin
				cell_valid_q <= '0;
			end else if (write) begin
				cell_valid_q[req_s1.addr] <= 1'b1;
			end
			if (req.hit) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign res_valid = valid_s1;

	always_comb begin
		res.result_kind  = req_s1.is_push ? amcc_pkg::KIND_ROW : amcc_pkg::KIND_READ;
		res.obs_class    = req_s1.obs_class;
		res.pred_class   = req_s1.pred_class;
		res.class_match  = req_s1.class_match;
		res.cell_count   = cnt;
		res.rows_seen    = req_s1.rows_seen;
		res.correct_rows = req_s1.correct_rows;
	end

endmodule

// ----- hw/rtl/argmax_confusion_matrix_counter_core.sv -----
`timescale 1ns / 1ps

// Streaming argmax confusion-matrix counter. Requests may follow back to back, one per
// cycle, while m_axis_tready does not hold back the output; a result passes through the
// store stage, the registered read-modify-write of the 256-entry count memory (with
// forwarding between neighboring updates), and then the output register. Request codes on
// s_axis_tuser: 0 pushes a score pair, 1 reads a cell, 2 clears all counts, 3 is ignored.
// Reads always give a result, pushes only on a row's last column, clears never. Reset
// and clear take effect at once via per-cell valid flags; no clearing pass follows reset.
module argmax_confusion_matrix_counter_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [4:0]   cfg_data,        // num_classes
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [39:0]  s_axis_tdata,    // pred_score, obs_score, read_row, read_col
	input  logic [1:0]   s_axis_tuser,    // req_type
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [111:0] m_axis_tdata,    // obs_class, pred_class, class_match, cell_count,
	                                      // rows_seen, correct_rows, zero fill
	output logic [0:0]   m_axis_tuser     // result_kind
);

	amcc_pkg::cell_req_t req;
	amcc_pkg::result_t   res;
	amcc_pkg::result_t   result_q;
	logic                clear;
	logic                res_valid;
	logic                adv;
	logic                accept;
	logic                m_valid_q;

	assign cfg_ready     = 1'b1;
	assign adv           = !m_valid_q || m_axis_tready;
	assign s_axis_tready = !res_valid || adv;
	assign accept        = s_axis_tvalid && s_axis_tready;

	amcc_row_track u_row_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.req_type   (s_axis_tuser),
		.pred_score (s_axis_tdata[15:0]),
		.obs_score  (s_axis_tdata[31:16]),
		.read_row   (s_axis_tdata[35:32]),
		.read_col   (s_axis_tdata[39:36]),
		.req        (req),
		.clear      (clear)
	);

	amcc_cell_store u_cell_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.clear     (clear),
		.adv       (adv),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			result_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = result_q.result_kind;
	assign m_axis_tdata  = {7'b0, result_q.correct_rows, result_q.rows_seen,
		result_q.cell_count, result_q.class_match, result_q.pred_class,
		result_q.obs_class};

endmodule
